/* src/ctl_lex_pkg.sv */
// shared types and character constants for the config text lexer
`timescale 1ns / 1ps

package ctl_lex_pkg;

  localparam int MaxRes = 4;

  // result event codes
  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;
  localparam logic [1:0] EV_DONE = 2'd3;

  // token kinds
  localparam logic [2:0] K_OP    = 3'd0;
  localparam logic [2:0] K_NAME  = 3'd1;
  localparam logic [2:0] K_INT   = 3'd2;
  localparam logic [2:0] K_FLOAT = 3'd3;
  localparam logic [2:0] K_STR   = 3'd4;

  // characters
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] chr;
    logic [2:0] kind;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [2:0]        cnt;
    logic [31:0]       line;
    // line of the done result, which follows a newline on the same byte
    logic [31:0]       line_done;
  } batch_t;

  function automatic res_t mk_res(logic [1:0] ev, logic [7:0] chr, logic [2:0] kind);
    res_t r;
    r.ev   = ev;
    r.chr  = chr;
    r.kind = kind;
    return r;
  endfunction

endpackage

/* src/ctl_lex_core.sv */
// lexer state and per-byte result builder
`timescale 1ns / 1ps

module ctl_lex_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_byte,
  input  logic                end_of_text,
  output ctl_lex_pkg::batch_t batch
);
  import ctl_lex_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_NAME = 3'd1,
    M_NUM  = 3'd2,
    M_STR  = 3'd3,
    M_DROP = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic        saw_dot, saw_dot_next;
  logic [31:0] line_count, line_count_next;

  logic is_digit, is_alpha, is_oper;

  assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign is_alpha = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                    ((char_byte >= 8'h41) && (char_byte <= 8'h5A));
  assign is_oper  = (char_byte == CH_COMMA)  || (char_byte == CH_EQ) ||
                    (char_byte == CH_LBRACE) || (char_byte == CH_RBRACE) ||
                    (char_byte == CH_LBRACK) || (char_byte == CH_RBRACK);

  always_comb begin
    logic [2:0]               n;
    logic                     fresh;
    res_t [MaxRes-1:0]        ent;
    logic [31:0]              done_line;
    mode_next       = mode;
    saw_dot_next    = saw_dot;
    line_count_next = line_count;
    n               = 3'd0;
    fresh           = 1'b0;
    ent             = '0;
    done_line       = line_count;

    unique case (mode)
      M_NAME: begin
        if (is_alpha || is_digit || char_byte == CH_UNDER || char_byte == CH_DOT) begin
          ent[n[1:0]] = mk_res(EV_CHAR, char_byte, K_NAME);
          n = n + 3'd1;
        end else begin
          ent[n[1:0]] = mk_res(EV_END, 8'd0, K_NAME);
          n = n + 3'd1;
          mode_next = M_IDLE;
          fresh = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit || char_byte == CH_DOT) begin
          if (char_byte == CH_DOT) saw_dot_next = 1'b1;
          ent[n[1:0]] = mk_res(EV_CHAR, char_byte, saw_dot_next ? K_FLOAT : K_INT);
          n = n + 3'd1;
        end else begin
          ent[n[1:0]] = mk_res(EV_END, 8'd0, saw_dot ? K_FLOAT : K_INT);
          n = n + 3'd1;
          mode_next = M_IDLE;
          saw_dot_next = 1'b0;
          fresh = 1'b1;
        end
      end
      M_STR: begin
        if (char_byte == CH_QUOTE) begin
          ent[n[1:0]] = mk_res(EV_END, 8'd0, K_STR);
          mode_next = M_IDLE;
        end else begin
          ent[n[1:0]] = mk_res(EV_CHAR, char_byte, K_STR);
        end
        n = n + 3'd1;
      end
      M_DROP: begin
      end
      default: begin
        mode_next = M_IDLE;
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      priority if (char_byte == CH_SPACE || char_byte == CH_TAB) begin
      end else if (char_byte == CH_NL) begin
        if (line_count != 32'hFFFF_FFFF) line_count_next = line_count + 32'd1;
      end else if (is_oper) begin
        ent[n[1:0]] = mk_res(EV_CHAR, char_byte, K_OP);
        n = n + 3'd1;
        ent[n[1:0]] = mk_res(EV_END, 8'd0, K_OP);
        n = n + 3'd1;
      end else if (is_alpha || char_byte == CH_UNDER) begin
        ent[n[1:0]] = mk_res(EV_CHAR, char_byte, K_NAME);
        n = n + 3'd1;
        mode_next = M_NAME;
      end else if (is_digit || char_byte == CH_MINUS) begin
        saw_dot_next = 1'b0;
        ent[n[1:0]] = mk_res(EV_CHAR, char_byte, K_INT);
        n = n + 3'd1;
        mode_next = M_NUM;
      end else if (char_byte == CH_QUOTE) begin
        mode_next = M_STR;
      end else begin
        ent[n[1:0]] = mk_res(EV_ERR, char_byte, K_OP);
        n = n + 3'd1;
        mode_next = M_DROP;
      end
    end

    if (end_of_text) begin
      // the done result sees a newline counted on this same byte
      done_line = line_count_next;
      // close any open token before the done result
      unique case (mode_next)
        M_NAME: begin
          ent[n[1:0]] = mk_res(EV_END, 8'd0, K_NAME);
          n = n + 3'd1;
        end
        M_NUM: begin
          ent[n[1:0]] = mk_res(EV_END, 8'd0, saw_dot_next ? K_FLOAT : K_INT);
          n = n + 3'd1;
        end
        M_STR: begin
          ent[n[1:0]] = mk_res(EV_END, 8'd0, K_STR);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      ent[n[1:0]] = mk_res(EV_DONE, 8'd0, K_OP);
      n = n + 3'd1;
      mode_next = M_IDLE;
      saw_dot_next = 1'b0;
      line_count_next = 32'd1;
    end

    batch.ent       = ent;
    batch.cnt       = n;
    batch.line      = line_count;
    batch.line_done = done_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      saw_dot    <= 1'b0;
      line_count <= 32'd1;
    end else if (accept) begin
      mode       <= mode_next;
      saw_dot    <= saw_dot_next;
      line_count <= line_count_next;
    end
  end

endmodule

/* src/ctl_lex_outq.sv */
// result register that hands out one byte's results one per cycle while res_stall is low
`timescale 1ns / 1ps

module ctl_lex_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ctl_lex_pkg::batch_t batch_in,
  output logic                free,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [1:0]          event_res,
  output logic [7:0]          token_byte,
  output logic [2:0]          token_kind,
  output logic [31:0]         line_number,
  output logic                last_result
);
  import ctl_lex_pkg::*;

  batch_t     bat;
  logic [2:0] cnt;
  logic [1:0] idx;
  logic       take;

  assign res_valid   = (cnt != 3'd0);
  assign take        = res_valid && !res_stall;
  assign last_result = (({1'b0, idx} + 3'd1) == cnt);
  // a new transaction may load in the cycle the final result leaves
  assign free        = !res_valid || (take && last_result);

  assign event_res   = bat.ent[idx].ev;
  assign token_byte  = bat.ent[idx].chr;
  assign token_kind  = bat.ent[idx].kind;
  assign line_number = (bat.ent[idx].ev == EV_DONE) ? bat.line_done : bat.line;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= batch_in.cnt;
      idx <= 2'd0;
    end else if (take) begin
      if (last_result) begin
        cnt <= 3'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) bat <= batch_in;
  end

endmodule

/* src/config_text_lexer.sv */
// top level of the config text lexer
`timescale 1ns / 1ps
//
// channel   handshake              payload
// item      item_valid/item_stall  char_byte, end_of_text
// result    res_valid/res_stall    event_res, token_byte, token_kind, line_number,
//                                  last_result
//
// one input byte is accepted per cycle while each byte causes at most one result and res_stall
// is low; a byte that causes several results holds the input until its last result leaves
// bytes that cause no result (blanks, newlines, dropped bytes) never load the result register
// rst is synchronous; after it the lexer is between tokens on line 1
// item_stall is high while earlier results are still in the result register, except as the final one leaves
module config_text_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_text,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  event_res,
  output logic [7:0]  token_byte,
  output logic [2:0]  token_kind,
  output logic [31:0] line_number,
  output logic        last_result
);
  import ctl_lex_pkg::*;

  batch_t batch;
  logic   free;
  logic   accept;

  assign item_stall = !free;
  assign accept     = item_valid && free;

  ctl_lex_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_byte   (char_byte),
    .end_of_text (end_of_text),
    .batch       (batch)
  );

  ctl_lex_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .load        (accept && (batch.cnt != 3'd0)),
    .batch_in    (batch),
    .free        (free),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .event_res   (event_res),
    .token_byte  (token_byte),
    .token_kind  (token_kind),
    .line_number (line_number),
    .last_result (last_result)
  );

endmodule

/* tb/config_text_lexer_tb.sv */
// self-checking testbench for the config text lexer
`timescale 1ns / 1ps

module config_text_lexer_tb;
  import ctl_lex_pkg::*;

  localparam int CycleLimit = 200000;

  typedef enum logic [2:0] {
    LX_IDLE = 3'd0,
    LX_NAME = 3'd1,
    LX_NUM  = 3'd2,
    LX_STR  = 3'd3,
    LX_DROP = 3'd4
  } lex_mode_t;

  typedef struct {
    logic [7:0] chr;
    logic       eot;
  } text_byte_t;

  typedef struct {
    logic [1:0]  ev;
    logic [7:0]  chr;
    logic [2:0]  kind;
    logic [31:0] line;
    logic        last;
  } token_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  char_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  event_res;
  logic [7:0]  token_byte;
  logic [2:0]  token_kind;
  logic [31:0] line_number;
  logic        last_result;

  text_byte_t text_q[$];
  token_res_t tokens_due[$];

  lex_mode_t   lx_mode;
  logic        lx_dot;
  logic [31:0] lx_line;

  logic [7:0] op_chars[6] = '{CH_COMMA, CH_EQ, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK};

  int text_total = 0;
  int busy_bytes = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 8;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [15:0] rx_cycle = 16'd0;
  text_byte_t next_byte;
  token_res_t want;

  config_text_lexer uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void emit(input logic [1:0] ev, input logic [7:0] chr,
                               input logic [2:0] kind);
    token_res_t r;
    r.ev   = ev;
    r.chr  = chr;
    r.kind = kind;
    r.line = lx_line;
    r.last = 1'b0;
    tokens_due.insert(tokens_due.size(), r);
  endfunction

  // works out every result one accepted byte causes
  function automatic void lex_predict(input logic [7:0] c, input logic eot);
    bit fresh;
    int n0;
    fresh = 1'b0;
    n0 = tokens_due.size();
    case (lx_mode)
      LX_NAME: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT) begin
          emit(EV_CHAR, c, K_NAME);
        end else begin
          emit(EV_END, 8'd0, K_NAME);
          lx_mode = LX_IDLE;
          fresh = 1'b1;
        end
      end
      LX_NUM: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (c == CH_DOT) lx_dot = 1'b1;
          emit(EV_CHAR, c, lx_dot ? K_FLOAT : K_INT);
        end else begin
          emit(EV_END, 8'd0, lx_dot ? K_FLOAT : K_INT);
          lx_mode = LX_IDLE;
          lx_dot = 1'b0;
          fresh = 1'b1;
        end
      end
      LX_STR: begin
        if (c == CH_QUOTE) begin
          emit(EV_END, 8'd0, K_STR);
          lx_mode = LX_IDLE;
        end else begin
          emit(EV_CHAR, c, K_STR);
        end
      end
      LX_DROP: ;
      default: begin
        lx_mode = LX_IDLE;
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      if (c == CH_SPACE || c == CH_TAB) begin
      end else if (c == CH_NL) begin
        if (lx_line != 32'hFFFF_FFFF) lx_line = lx_line + 32'd1;
      end else if (c == CH_COMMA || c == CH_EQ || c == CH_LBRACE || c == CH_RBRACE ||
                   c == CH_LBRACK || c == CH_RBRACK) begin
        emit(EV_CHAR, c, K_OP);
        emit(EV_END, 8'd0, K_OP);
      end else if (is_alpha(c) || c == CH_UNDER) begin
        emit(EV_CHAR, c, K_NAME);
        lx_mode = LX_NAME;
      end else if (is_digit(c) || c == CH_MINUS) begin
        lx_dot = 1'b0;
        emit(EV_CHAR, c, K_INT);
        lx_mode = LX_NUM;
      end else if (c == CH_QUOTE) begin
        lx_mode = LX_STR;
      end else begin
        emit(EV_ERR, c, K_OP);
        lx_mode = LX_DROP;
      end
    end

    if (eot) begin
      if (lx_mode == LX_NAME) emit(EV_END, 8'd0, K_NAME);
      else if (lx_mode == LX_NUM) emit(EV_END, 8'd0, lx_dot ? K_FLOAT : K_INT);
      else if (lx_mode == LX_STR) emit(EV_END, 8'd0, K_STR);
      emit(EV_DONE, 8'd0, K_OP);
      lx_mode = LX_IDLE;
      lx_dot = 1'b0;
      lx_line = 32'd1;
    end

    if (tokens_due.size() > n0) begin
      tokens_due[tokens_due.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic queue_byte(input logic [7:0] c, input logic eot);
    text_byte_t b;
    b.chr = c;
    b.eot = eot;
    text_q.insert(text_q.size(), b);
    if (c != CH_SPACE && c != CH_TAB) busy_bytes++;
  endtask

  task automatic end_stream();
    if (text_q.size() != 0) begin
      text_q[text_q.size() - 1].eot = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("mismatch in %s at result %0d: expected %0h, got %0h",
             field, results_seen, exp_val, got_val);
    mismatches++;
  endtask

  // stimulus: directed streams, then random token sequences
  initial begin
    int pick;
    int len;
    logic [7:0] c;
    // name closed by an operator, float, empty string, newline inside a string
    queue_byte(CH_LBRACE, 1'b0);
    queue_byte("a", 1'b0);
    queue_byte(CH_UNDER, 1'b0);
    queue_byte("9", 1'b0);
    queue_byte(CH_DOT, 1'b0);
    queue_byte(CH_EQ, 1'b0);
    queue_byte(CH_MINUS, 1'b0);
    queue_byte("7", 1'b0);
    queue_byte(CH_DOT, 1'b0);
    queue_byte(CH_COMMA, 1'b0);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_LBRACK, 1'b0);
    queue_byte(CH_RBRACK, 1'b0);
    queue_byte(CH_RBRACE, 1'b0);
    queue_byte("x", 1'b1);
    // open number and unterminated string closed by end of stream
    queue_byte("5", 1'b1);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte("q", 1'b1);
    // number ended by an operator on the last byte
    queue_byte("1", 1'b0);
    queue_byte(CH_RBRACE, 1'b1);
    // unresolved bytes, rest of stream dropped
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0D, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // newline on the final byte moves the done line
    queue_byte(CH_NL, 1'b1);

    busy_bytes = 0;
    while (busy_bytes < 90) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        queue_byte(op_chars[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 32) begin
        if ($urandom_range(0, 4) == 0) c = CH_UNDER;
        else if ($urandom_range(0, 1) == 0) c = 8'($urandom_range("a", "z"));
        else c = 8'($urandom_range("A", "Z"));
        queue_byte(c, 1'b0);
        len = $urandom_range(0, 5);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: c = 8'($urandom_range("a", "z"));
            1: c = 8'($urandom_range("A", "Z"));
            2: c = 8'($urandom_range("0", "9"));
            default: c = $urandom_range(0, 1) ? CH_UNDER : CH_DOT;
          endcase
          queue_byte(c, 1'b0);
        end
      end else if (pick < 50) begin
        c = ($urandom_range(0, 3) == 0) ? CH_MINUS : 8'($urandom_range("0", "9"));
        queue_byte(c, 1'b0);
        len = $urandom_range(0, 5);
        repeat (len) begin
          c = ($urandom_range(0, 4) == 0) ? CH_DOT : 8'($urandom_range("0", "9"));
          queue_byte(c, 1'b0);
        end
      end else if (pick < 62) begin
        queue_byte(CH_QUOTE, 1'b0);
        len = $urandom_range(0, 4);
        repeat (len) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE || $urandom_range(0, 7) == 0) c = CH_NL;
          queue_byte(c, 1'b0);
        end
        if ($urandom_range(0, 7) != 0) queue_byte(CH_QUOTE, 1'b0);
        else end_stream();
      end else if (pick < 76) begin
        case ($urandom_range(0, 2))
          0: queue_byte(CH_SPACE, 1'b0);
          1: queue_byte(CH_TAB, 1'b0);
          default: queue_byte(CH_NL, 1'b0);
        endcase
      end else if (pick < 90) begin
        queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 1) == 0) begin
          queue_byte(8'($urandom_range(0, 255)), 1'b0);
          queue_byte(8'($urandom_range(0, 255)), 1'b0);
          end_stream();
        end
      end else begin
        end_stream();
      end
    end
    end_stream();
    text_total = text_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < text_total) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      lx_mode = LX_IDLE;
      lx_dot = 1'b0;
      lx_line = 32'd1;
    end else begin
      if (item_valid && !item_stall) begin
        lex_predict(char_byte, end_of_text);
        bytes_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0 || text_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          item_valid <= 1'b0;
        end else begin
          next_byte = text_q.pop_front();
          item_valid <= 1'b1;
          char_byte <= next_byte.chr;
          end_of_text <= next_byte.eot;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back up the input
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (!hold_done && bytes_taken >= 40) begin
      hold_done = 1'b1;
      hold_left = 90;
      res_stall <= 1'b1;
    end else begin
      case (rx_cycle[8:7])
        2'd0: res_stall <= 1'b0;
        2'd1: res_stall <= ($urandom_range(0, 9) < 3);
        2'd2: res_stall <= ($urandom_range(0, 9) < 7);
        default: res_stall <= (rx_cycle[1:0] == 2'd3);
      endcase
    end
  end

  // monitor: each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected result event", 32'd0, 32'(event_res));
      end else begin
        want = tokens_due.pop_front();
        if (event_res !== want.ev) report_mismatch("event_res", 32'(want.ev), 32'(event_res));
        if (token_byte !== want.chr)
          report_mismatch("token_byte", 32'(want.chr), 32'(token_byte));
        if (token_kind !== want.kind)
          report_mismatch("token_kind", 32'(want.kind), 32'(token_kind));
        if (line_number !== want.line) report_mismatch("line_number", want.line, line_number);
        if (last_result !== want.last)
          report_mismatch("last_result", 32'(want.last), 32'(last_result));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

/* filelist.f */
src/ctl_lex_pkg.sv
src/ctl_lex_core.sv
src/ctl_lex_outq.sv
src/config_text_lexer.sv
tb/config_text_lexer_tb.sv
